[sv/uart_command_gain_parser_unit_assert.svh]
// Assertion macros used by the parser top level.
`ifndef UART_COMMAND_GAIN_PARSER_UNIT_ASSERT_SVH
`define UART_COMMAND_GAIN_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define UCGP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucgp assertion failed");

// next-cycle implication, checked outside reset
`define UCGP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucgp assertion failed");

`else

`define UCGP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define UCGP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[sv/ucgp_pkg.sv]
// Shared constants, types and constant tables of the command and gain parser.
package ucgp_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 3;
  localparam int SEL_W     = 3;
  localparam int VAL_W     = 48;
  localparam int FRAC_BITS = 16;

  // frame limits
  localparam int MAX_FRAME_BYTES = 20;
  localparam int MAX_VALUE_CHARS = 10;
  localparam int POS_W           = 5;
  localparam int CNT_W           = 4;
  localparam int KEY_LETTER_POS  = 2;
  localparam int KEY_DIGIT_POS   = 3;
  localparam int VALUE_POS       = 5;

  // arithmetic widths
  localparam int MAG_W  = BYTE_W + FRAC_BITS;   // |digit| scaled to fixed point
  localparam int NUM_W  = MAG_W + 1;            // dividend incl. rounding half
  localparam int RCP_W  = NUM_W + 2;            // reciprocal width
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int SH_W   = $clog2(2 * NUM_W + 1);
  localparam int ADD_W  = MAG_W + 1;            // signed term into the accumulator
  localparam int SUM_W  = VAL_W + 5;            // acc*10 + term without overflow
  localparam int DIG_N  = 2 ** CNT_W;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // byte codes
  localparam logic [BYTE_W-1:0] BYTE_FORWARD  = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_BACKWARD = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_STOP     = 8'h05;
  localparam logic [BYTE_W-1:0] BYTE_LEFT     = 8'h04;
  localparam logic [BYTE_W-1:0] BYTE_RIGHT    = 8'h06;
  localparam logic [BYTE_W-1:0] CH_OPEN       = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_CLOSE      = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_EMIT       = 8'h23;
  localparam logic [BYTE_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NUL        = 8'h00;
  localparam logic [BYTE_W-1:0] KEY_P         = 8'h70;
  localparam logic [BYTE_W-1:0] KEY_D         = 8'h64;
  localparam logic [BYTE_W-1:0] KEY_I         = 8'h69;
  localparam logic [BYTE_W-1:0] KEY_1         = 8'h31;
  localparam logic [BYTE_W-1:0] KEY_2         = 8'h32;
  localparam logic [BYTE_W-1:0] KEY_3         = 8'h33;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE, CMD_FORWARD, CMD_BACKWARD, CMD_STOP, CMD_LEFT, CMD_RIGHT
  } drive_cmd_t;

  typedef enum logic [SEL_W-1:0] {
    GAIN_UP_P, GAIN_UP_D, GAIN_SPD_P, GAIN_SPD_I, GAIN_TURN_P, GAIN_TURN_D
  } gain_sel_t;

  // accumulator operation carried with each item
  typedef enum logic [2:0] {
    OP_NONE, OP_SHIFT_ADD, OP_ADD, OP_EMIT, OP_CLEAR
  } acc_op_t;

  typedef struct packed {
    acc_op_t                   op;
    logic signed [ADD_W-1:0]   addend;
    drive_cmd_t                drive;
    gain_sel_t                 sel;
  } acc_item_t;

  // elaboration-time helpers for the fraction divider tables
  function automatic logic [127:0] pow10(input int n);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < n; i++) p = p * 128'd10;
    return p;
  endfunction

  function automatic int rshift10(input int n);
    return NUM_W + $clog2(pow10(n));
  endfunction

  function automatic logic [127:0] rcp_num(input int n);
    return (128'd1 << rshift10(n)) + pow10(n) - 128'd1;
  endfunction

  typedef logic [NUM_W-1:0] half_tab_t [DIG_N];
  typedef logic [SH_W-1:0]  shift_tab_t [DIG_N];
  typedef logic [RCP_W-1:0] rcp_tab_t [DIG_N];

  function automatic half_tab_t mk_half();
    half_tab_t t;
    for (int i = 0; i < DIG_N; i++) t[i] = NUM_W'(pow10(i) >> 1);
    return t;
  endfunction

  function automatic shift_tab_t mk_shift();
    shift_tab_t t;
    for (int i = 0; i < DIG_N; i++) t[i] = SH_W'(rshift10(i));
    return t;
  endfunction

  // a divisor is live while half of it stays below 2^MAG_W; beyond that
  // every scaled digit rounds to zero
  function automatic logic [DIG_N-1:0] mk_live();
    logic [DIG_N-1:0] t;
    for (int i = 0; i < DIG_N; i++) t[i] = (pow10(i) >> 1) < (128'd1 << MAG_W);
    return t;
  endfunction

  localparam half_tab_t        HALF10  = mk_half();
  localparam shift_tab_t       SHIFT10 = mk_shift();
  localparam logic [DIG_N-1:0] LIVE10  = mk_live();

  // ceil(2^k / 10^n), exact quotient for any dividend below 2^NUM_W
  localparam rcp_tab_t RCP10 = '{
    RCP_W'(rcp_num(0)  / pow10(0)),
    RCP_W'(rcp_num(1)  / pow10(1)),
    RCP_W'(rcp_num(2)  / pow10(2)),
    RCP_W'(rcp_num(3)  / pow10(3)),
    RCP_W'(rcp_num(4)  / pow10(4)),
    RCP_W'(rcp_num(5)  / pow10(5)),
    RCP_W'(rcp_num(6)  / pow10(6)),
    RCP_W'(rcp_num(7)  / pow10(7)),
    RCP_W'(rcp_num(8)  / pow10(8)),
    RCP_W'(rcp_num(9)  / pow10(9)),
    RCP_W'(rcp_num(10) / pow10(10)),
    RCP_W'(rcp_num(11) / pow10(11)),
    RCP_W'(rcp_num(12) / pow10(12)),
    RCP_W'(rcp_num(13) / pow10(13)),
    RCP_W'(rcp_num(14) / pow10(14)),
    RCP_W'(rcp_num(15) / pow10(15))
  };

endpackage

[sv/ucgp_in_if.sv]
// Input channel: one received byte per item.
interface ucgp_in_if;
  import ucgp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/ucgp_out_if.sv]
// Output channel: drive command and gain update per item.
interface ucgp_out_if;
  import ucgp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        drive_command;
  logic                    gain_update;
  logic [SEL_W-1:0]        gain_select;
  logic signed [VAL_W-1:0] gain_value;

  modport source (output valid, output drive_command, output gain_update,
                  output gain_select, output gain_value, input ready);
  modport sink   (input valid, input drive_command, input gain_update,
                  input gain_select, input gain_value, output ready);
endinterface

[sv/ucgp_frac_div.sv]
// Rounded division of a scaled digit by 10^n through a reciprocal multiply.
module ucgp_frac_div (
  input  logic [ucgp_pkg::MAG_W-1:0] mag,
  input  logic [ucgp_pkg::CNT_W-1:0] digits,
  output logic [ucgp_pkg::MAG_W-1:0] quot
);
  import ucgp_pkg::*;

  logic [NUM_W-1:0]  num;
  logic [RCP_W-1:0]  rcp;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] shifted;

  // add half the divisor for round-to-nearest, then multiply by the reciprocal
  assign num     = NUM_W'(mag) + HALF10[digits];
  assign rcp     = RCP10[digits];
  assign prod    = PROD_W'(num) * PROD_W'(rcp);
  assign shifted = prod >> SHIFT10[digits];
  assign quot    = LIVE10[digits] ? shifted[MAG_W-1:0] : '0;

endmodule

[sv/ucgp_parse.sv]
// Frame parser stage: tracks frame and value state, registers one op per byte.
module ucgp_parse (
  input  logic                 clk,
  input  logic                 rst,
  ucgp_in_if.sink              rx,
  input  logic                 take,
  output logic                 item_valid,
  output ucgp_pkg::acc_item_t  item
);
  import ucgp_pkg::*;

  logic              frame_open, frame_open_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [BYTE_W-1:0] key_letter, key_letter_next;
  logic [BYTE_W-1:0] key_digit, key_digit_next;
  logic              dot_seen, dot_seen_next;
  logic [CNT_W-1:0]  digits_after_dot, digits_after_dot_next;
  logic [CNT_W-1:0]  value_chars, value_chars_next;
  logic              value_ended, value_ended_next;
  acc_item_t         item_next;

  logic [BYTE_W-1:0]       b;
  logic                    accept;
  logic [POS_W-1:0]        pos_inc;
  logic [CNT_W-1:0]        dad_inc;
  logic signed [BYTE_W:0]  d;
  logic [BYTE_W-1:0]       d_mag;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        quot;
  logic signed [ADD_W-1:0] whole_term;
  logic signed [ADD_W-1:0] frac_term;
  drive_cmd_t              drive;
  logic                    key_hit;
  gain_sel_t               key_sel;

  assign b        = rx.rx_byte;
  assign rx.ready = !item_valid || take;
  assign accept   = rx.valid && rx.ready;
  assign pos_inc  = byte_position + POS_W'(1);
  assign dad_inc  = (digits_after_dot == '1) ? digits_after_dot
                                             : digits_after_dot + CNT_W'(1);

  // digit value: byte minus '0', any byte counts
  assign d     = $signed({1'b0, b}) - $signed({1'b0, CH_ZERO});
  assign d_mag = d[BYTE_W] ? BYTE_W'(-d) : d[BYTE_W-1:0];
  assign mag   = {d_mag, {FRAC_BITS{1'b0}}};

  assign whole_term = ADD_W'(d) <<< FRAC_BITS;
  assign frac_term  = d[BYTE_W] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  ucgp_frac_div u_frac_div (
    .mag    (mag),
    .digits (dad_inc),
    .quot   (quot)
  );

  // drive byte decode
  always_comb begin
    unique case (b)
      BYTE_FORWARD:  drive = CMD_FORWARD;
      BYTE_BACKWARD: drive = CMD_BACKWARD;
      BYTE_STOP:     drive = CMD_STOP;
      BYTE_LEFT:     drive = CMD_LEFT;
      BYTE_RIGHT:    drive = CMD_RIGHT;
      default:       drive = CMD_NONE;
    endcase
  end

  // two-letter key decode
  always_comb begin
    key_hit = 1'b1;
    key_sel = GAIN_UP_P;
    if (key_letter == KEY_P && key_digit == KEY_1)      key_sel = GAIN_UP_P;
    else if (key_letter == KEY_D && key_digit == KEY_1) key_sel = GAIN_UP_D;
    else if (key_letter == KEY_P && key_digit == KEY_2) key_sel = GAIN_SPD_P;
    else if (key_letter == KEY_I && key_digit == KEY_2) key_sel = GAIN_SPD_I;
    else if (key_letter == KEY_P && key_digit == KEY_3) key_sel = GAIN_TURN_P;
    else if (key_letter == KEY_D && key_digit == KEY_3) key_sel = GAIN_TURN_D;
    else key_hit = 1'b0;
  end

  // frame and value state update, op selection
  always_comb begin
    frame_open_next       = frame_open;
    byte_position_next    = byte_position;
    key_letter_next       = key_letter;
    key_digit_next        = key_digit;
    dot_seen_next         = dot_seen;
    digits_after_dot_next = digits_after_dot;
    value_chars_next      = value_chars;
    value_ended_next      = value_ended;
    item_next.op          = OP_NONE;
    item_next.addend      = '0;
    item_next.drive       = drive;
    item_next.sel         = GAIN_UP_P;

    if (b == CH_OPEN) begin
      frame_open_next       = 1'b1;
      byte_position_next    = '0;
      key_letter_next       = '0;
      key_digit_next        = '0;
      dot_seen_next         = 1'b0;
      digits_after_dot_next = '0;
      value_chars_next      = '0;
      value_ended_next      = 1'b0;
      item_next.op          = OP_CLEAR;
    end else if (frame_open) begin
      if (b == CH_CLOSE || pos_inc >= POS_W'(MAX_FRAME_BYTES)) begin
        frame_open_next    = 1'b0;
        byte_position_next = '0;
      end else begin
        byte_position_next = pos_inc;
        if (pos_inc == POS_W'(KEY_LETTER_POS)) key_letter_next = b;
        if (pos_inc == POS_W'(KEY_DIGIT_POS))  key_digit_next  = b;
        if (pos_inc >= POS_W'(VALUE_POS)) begin
          if (b == CH_EMIT) begin
            // emit on a known key, empty the value either way
            item_next.op          = key_hit ? OP_EMIT : OP_CLEAR;
            item_next.sel         = key_hit ? key_sel : GAIN_UP_P;
            dot_seen_next         = 1'b0;
            digits_after_dot_next = '0;
            value_chars_next      = '0;
            value_ended_next      = 1'b1;
          end else if (!value_ended && value_chars < CNT_W'(MAX_VALUE_CHARS)) begin
            if (b == CH_NUL) begin
              value_ended_next = 1'b1;
            end else begin
              value_chars_next = value_chars + CNT_W'(1);
              if (b == CH_DOT) begin
                dot_seen_next         = 1'b1;
                digits_after_dot_next = '0;
              end else if (!dot_seen) begin
                item_next.op     = OP_SHIFT_ADD;
                item_next.addend = whole_term;
              end else begin
                digits_after_dot_next = dad_inc;
                item_next.op          = OP_ADD;
                item_next.addend      = frac_term;
              end
            end
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open       <= 1'b0;
      byte_position    <= '0;
      key_letter       <= '0;
      key_digit        <= '0;
      dot_seen         <= 1'b0;
      digits_after_dot <= '0;
      value_chars      <= '0;
      value_ended      <= 1'b0;
      item_valid       <= 1'b0;
    end else begin
      if (accept) begin
        frame_open       <= frame_open_next;
        byte_position    <= byte_position_next;
        key_letter       <= key_letter_next;
        key_digit        <= key_digit_next;
        dot_seen         <= dot_seen_next;
        digits_after_dot <= digits_after_dot_next;
        value_chars      <= value_chars_next;
        value_ended      <= value_ended_next;
      end
      if (rx.ready) item_valid <= rx.valid;
    end
  end

  // op register
  always_ff @(posedge clk) begin
    if (accept) item <= item_next;
  end

endmodule

[sv/ucgp_accum.sv]
// Value accumulator with saturation and the result register.
module ucgp_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  ucgp_pkg::acc_item_t  item,
  output logic                 take,
  ucgp_out_if.source           result
);
  import ucgp_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(VAL_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(VAL_MIN);

  logic signed [VAL_W-1:0] acc, acc_next;
  logic                    out_valid;
  logic [CMD_W-1:0]        out_drive;
  logic                    out_update;
  logic [SEL_W-1:0]        out_sel;
  logic signed [VAL_W-1:0] out_value;

  logic signed [SUM_W-1:0] acc_wide;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] sat_val;

  assign take = item_valid && (!out_valid || result.ready);

  // acc*10 by shift-add on OP_SHIFT_ADD (acc as is otherwise), add the term, clamp to the value range
  always_comb begin
    acc_wide = SUM_W'(acc);
    base     = (item.op == OP_SHIFT_ADD) ? (acc_wide <<< 3) + (acc_wide <<< 1) : acc_wide;
    sum      = base + SUM_W'(item.addend);
    if (sum > SUM_HI)      sat_val = VAL_MAX;
    else if (sum < SUM_LO) sat_val = VAL_MIN;
    else                   sat_val = sum[VAL_W-1:0];
  end

  always_comb begin
    unique case (item.op)
      OP_SHIFT_ADD, OP_ADD: acc_next = sat_val;
      OP_EMIT, OP_CLEAR:    acc_next = '0;
      default:              acc_next = acc;
    endcase
  end

  // accumulator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        acc       <= acc_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_drive  <= item.drive;
      out_update <= (item.op == OP_EMIT);
      out_sel    <= item.sel;
      out_value  <= (item.op == OP_EMIT) ? acc : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.drive_command = out_drive;
  assign result.gain_update   = out_update;
  assign result.gain_select   = out_sel;
  assign result.gain_value    = out_value;

endmodule

[sv/uart_command_gain_parser_unit.sv]
// Top level of the serial drive command and gain frame parser.
// Path: an accepted byte is held in the op register, then in the accumulator and
// result register. Throughput: one byte per cycle while the result is not stalled
// by result.ready; the accumulator update is a combinational loop on its register.
// Reset: synchronous rst closes any frame, zeroes the value and empties both stages.
`include "uart_command_gain_parser_unit_assert.svh"

module uart_command_gain_parser_unit (
  input  logic        clk,
  input  logic        rst,
  ucgp_in_if.sink     rx,
  ucgp_out_if.source  result
);
  import ucgp_pkg::*;

  logic      item_valid;
  acc_item_t item;
  logic      take;

  // byte parsing into accumulator ops
  ucgp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // value accumulation and result register
  ucgp_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .result     (result)
  );

  // checks
  `UCGP_ASSERT_IMPLY(a_update_no_drive, clk, rst, result.valid && result.gain_update, result.drive_command == CMD_NONE)
  `UCGP_ASSERT_IMPLY(a_quiet_zero, clk, rst, result.valid && !result.gain_update, result.gain_value == '0 && result.gain_select == GAIN_UP_P)
  `UCGP_ASSERT_NEXT(a_op_held, clk, rst, item_valid && !take, item_valid && $stable(item))

endmodule
